// File: design/flc_pkg.sv
// Package for the fixed-width leader clustering block.
// Holds sizes, the controller state type and the command/status structs.
package flc_pkg;

    localparam int MaxClusters = 64;
    localparam int CountBits   = 16;
    localparam int IdxBits     = $clog2(MaxClusters);
    localparam int CntBits     = IdxBits + 1;
    localparam int FeatBits    = 16;
    localparam int SumBits     = 32;
    localparam int DistBits    = 34;
    localparam logic [DistBits-1:0] WidthSqReset = DistBits'(65536);
    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
    // one RAM word per cluster: centroid a, centroid b, sum a, sum b, count
    localparam int WordBits = 2 * FeatBits + 2 * SumBits + CountBits;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_READ  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;       // capture sample, reset search
        logic rd_en;      // issue RAM read
        logic rd_best;    // read address is the best entry
        logic [IdxBits-1:0] rd_addr;
        logic cmp_en;     // compare RAM data of the previous read
        logic first;      // that compare is against entry 0
        logic [IdxBits-1:0] cmp_idx;
        logic upd_start;  // add sample to best entry and start dividers
        logic wr_join;    // write updated best entry
        logic wr_open;    // write new entry at cluster_count
        logic out_load;   // load result register
    } t_cmd;

    typedef struct packed {
        logic join_ok;    // best distance below width
        logic sat;        // best count saturated
        logic div_done;
    } t_sts;

endpackage

// File: design/flc_if.sv
// Valid/ready channel interfaces for the clustering block.
// No dependencies.
interface flc_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] feature_a;
    logic signed [15:0] feature_b;
    modport source (output valid, feature_a, feature_b, input ready);
    modport sink   (input valid, feature_a, feature_b, output ready);
endinterface

interface flc_out_if;
    logic valid;
    logic ready;
    logic [5:0]  cluster_index;
    logic        opened_new;
    logic        table_full;
    logic [15:0] cluster_members;
    modport source (output valid, cluster_index, opened_new, table_full, cluster_members,
                    input ready);
    modport sink   (input valid, cluster_index, opened_new, table_full, cluster_members,
                    output ready);
endinterface

// File: design/flc_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module flc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// File: design/flc_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on flc_pkg.
module flc_div (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic signed [flc_pkg::SumBits-1:0] i_num,
    input  logic [flc_pkg::CountBits-1:0] i_den,
    output logic o_done,
    output logic signed [flc_pkg::FeatBits-1:0] o_quot
);
    import flc_pkg::*;

    localparam int StepBits = $clog2(SumBits + 1);

    logic [SumBits-1:0]   r_q, n_q;
    logic [CountBits:0]   r_rem, n_rem;
    logic [CountBits-1:0] r_den;
    logic                 r_neg;
    logic [StepBits-1:0]  r_step;
    logic                 r_busy;
    logic [CountBits:0]   w_trial;
    logic [SumBits-1:0]   w_signed_q;

    // shift in one numerator bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem[CountBits-1:0], r_q[SumBits-1]};
        n_q     = {r_q[SumBits-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem   = w_trial - {1'b0, r_den};
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= StepBits'(SumBits);
            r_q    <= i_num[SumBits-1] ? SumBits'(-i_num) : i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_neg  <= i_num[SumBits-1];
        end else if (r_busy && r_step != '0) begin
            r_q    <= n_q;
            r_rem  <= n_rem;
            r_step <= r_step - 1'b1;
        end
    end

    assign w_signed_q = r_neg ? SumBits'(-r_q) : r_q;
    assign o_done     = r_busy && (r_step == '0);
    assign o_quot     = w_signed_q[FeatBits-1:0];
endmodule

// File: design/flc_ctrl.sv
// Controller state machine: scan, update and result sequencing.
// Depends on flc_pkg.
module flc_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_busy,
    input  flc_pkg::t_sts i_sts,
    input  logic [flc_pkg::CntBits-1:0] i_count,
    output flc_pkg::t_cmd o_cmd
);
    import flc_pkg::*;

    t_state r_state, n_state;
    logic [CntBits-1:0] r_ptr, n_ptr;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        o_cmd   = '0;
        o_cmd.rd_addr = r_ptr[IdxBits-1:0];
        o_cmd.cmp_idx = IdxBits'(r_ptr - 1'b1);
        o_cmd.first   = (r_ptr == CntBits'(1));
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_ptr      = '0;
                    n_state    = (i_count == '0) ? S_DRAIN : S_SCAN;
                end
            end
            S_SCAN: begin
                // read entry r_ptr, compare entry r_ptr-1
                o_cmd.rd_en  = 1'b1;
                o_cmd.cmp_en = (r_ptr != '0);
                n_ptr        = r_ptr + 1'b1;
                if (r_ptr + 1'b1 == i_count) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                o_cmd.cmp_en = (r_ptr != '0);
                n_state      = S_READ;
            end
            S_READ: begin
                if (i_sts.join_ok) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_best = 1'b1;
                    o_cmd.rd_addr = '0;
                    n_state       = S_DIV;
                    n_ptr         = '0;
                end else begin
                    o_cmd.wr_open = (i_count != CntBits'(MaxClusters));
                    n_state       = S_OUT;
                end
            end
            S_DIV: begin
                // r_ptr 0: RAM word of best entry arrives, start dividers unless saturated
                if (r_ptr == '0) begin
                    n_ptr = CntBits'(1);
                    if (!i_sts.sat) o_cmd.upd_start = 1'b1;
                    else n_state = S_OUT;
                end else if (i_sts.div_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_join = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end
endmodule

// File: design/flc_dp.sv
// Datapath: cluster RAM, distance compare, sum update, dividers, result register.
// Depends on flc_pkg, flc_ram, flc_div.
module flc_dp (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic signed [flc_pkg::FeatBits-1:0] i_feature_a,
    input  logic signed [flc_pkg::FeatBits-1:0] i_feature_b,
    input  logic [flc_pkg::DistBits-1:0] i_width_sq,
    input  flc_pkg::t_cmd i_cmd,
    output flc_pkg::t_sts o_sts,
    output logic [flc_pkg::CntBits-1:0] o_count,
    output logic o_out_valid,
    input  logic i_out_ready,
    output logic [5:0]  o_cluster_index,
    output logic        o_opened_new,
    output logic        o_table_full,
    output logic [15:0] o_cluster_members
);
    import flc_pkg::*;

    logic signed [FeatBits-1:0] r_a, r_b;
    logic [CntBits-1:0]  r_count;
    logic [DistBits-1:0] r_best_d;
    logic [IdxBits-1:0]  r_best;
    logic                r_found;
    logic [WordBits-1:0] w_rdata, w_wdata;
    logic                w_we;
    logic [IdxBits-1:0]  w_waddr;

    logic signed [FeatBits-1:0]  w_ca, w_cb;
    logic signed [SumBits-1:0]   w_sa, w_sb;
    logic [CountBits-1:0]        w_cnt;
    logic signed [FeatBits:0]    w_da, w_db;
    logic [2*FeatBits+1:0]       w_pa, w_pb;
    logic [DistBits-1:0]         w_d;

    logic signed [SumBits-1:0]   r_sa, r_sb;
    logic [CountBits-1:0]        r_cnt;
    logic signed [SumBits:0]     w_na, w_nb;
    logic signed [SumBits-1:0]   w_sat_a, w_sat_b;
    logic                        w_done_a, w_done_b;
    logic signed [FeatBits-1:0]  w_qa, w_qb;

    logic [5:0]  r_idx;
    logic        r_new, r_full, r_valid;
    logic [15:0] r_size;
    logic        r_open_seen, r_sat, r_sat_block;

    assign {w_ca, w_cb, w_sa, w_sb, w_cnt} = w_rdata;

    // squared distance of the sample to the word just read
    assign w_da = (FeatBits+1)'(r_a) - (FeatBits+1)'(w_ca);
    assign w_db = (FeatBits+1)'(r_b) - (FeatBits+1)'(w_cb);
    assign w_pa = (2*FeatBits+2)'(w_da * w_da);
    assign w_pb = (2*FeatBits+2)'(w_db * w_db);
    assign w_d  = DistBits'(w_pa) + DistBits'(w_pb);

    // running sums with signed saturation
    assign w_na = (SumBits+1)'(w_sa) + (SumBits+1)'(r_a);
    assign w_nb = (SumBits+1)'(w_sb) + (SumBits+1)'(r_b);
    assign w_sat_a = (w_na[SumBits] != w_na[SumBits-1]) ?
                     {w_na[SumBits], {(SumBits-1){~w_na[SumBits]}}} : w_na[SumBits-1:0];
    assign w_sat_b = (w_nb[SumBits] != w_nb[SumBits-1]) ?
                     {w_nb[SumBits], {(SumBits-1){~w_nb[SumBits]}}} : w_nb[SumBits-1:0];

    assign o_sts.join_ok  = r_found && (r_best_d < i_width_sq);
    assign o_sts.sat      = (w_cnt == CountMax);
    assign o_sts.div_done = w_done_a && w_done_b;
    assign o_count        = r_count;

    // RAM write: open a new entry or store the joined one
    assign w_we    = i_cmd.wr_open || i_cmd.wr_join;
    assign w_waddr = i_cmd.wr_open ? r_count[IdxBits-1:0] : r_best;
    assign w_wdata = i_cmd.wr_open ?
        {r_a, r_b, SumBits'(r_a), SumBits'(r_b), CountBits'(1)} :
        {w_qa, w_qb, r_sa, r_sb, r_cnt};

    flc_ram #(.Width(WordBits), .Depth(MaxClusters)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_best ? r_best : i_cmd.rd_addr),
        .o_rdata (w_rdata)
    );

    flc_div u_div_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.upd_start),
        .i_num(w_sat_a), .i_den(w_cnt + 1'b1), .o_done(w_done_a), .o_quot(w_qa));
    flc_div u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.upd_start),
        .i_num(w_sat_b), .i_den(w_cnt + 1'b1), .o_done(w_done_b), .o_quot(w_qb));

    function automatic logic r_full_n();
        return r_count == CntBits'(MaxClusters) && !r_open_seen;
    endfunction

    function automatic logic [CountBits-1:0] w_cnt_sel();
        return r_sat ? w_cnt : r_cnt;
    endfunction

    // sample capture, best search and update registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_feature_a;
            r_b <= i_feature_b;
        end
        if (i_cmd.cmp_en && (i_cmd.first || w_d < r_best_d)) begin
            r_best_d <= w_d;
            r_best   <= i_cmd.cmp_idx;
        end
        if (i_cmd.upd_start) begin
            r_sa  <= w_sat_a;
            r_sb  <= w_sat_b;
            r_cnt <= w_cnt + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_idx  <= o_sts.join_ok ? 6'(r_best) : (r_full_n() ? 6'd0 : 6'(r_count - 1'b1));
            r_new  <= !o_sts.join_ok && !r_full_n();
            r_full <= !o_sts.join_ok && r_full_n();
            r_size <= o_sts.join_ok ? 16'(w_cnt_sel()) : (r_full_n() ? 16'd0 : 16'd1);
        end
    end

    // control registers: cluster count, search valid, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_found     <= 1'b0;
            r_valid     <= 1'b0;
            r_open_seen <= 1'b0;
            r_sat       <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_found     <= (r_count != '0);
                r_open_seen <= 1'b0;
                r_sat       <= 1'b0;
            end
            if (i_cmd.wr_open) begin
                r_count     <= r_count + 1'b1;
                r_open_seen <= 1'b1;
            end
            if (o_sts.join_ok && o_sts.sat && !i_cmd.upd_start && !i_cmd.rd_en &&
                !i_cmd.wr_join && !i_cmd.out_load && !r_sat_block) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.upd_start) r_sat <= 1'b0;
            if (i_cmd.out_load) r_valid <= 1'b1;
            else if (i_out_ready) r_valid <= 1'b0;
        end
    end

    // saturation flag is sampled only while the best word is on the RAM output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_block <= 1'b1;
        end else begin
            r_sat_block <= !(i_cmd.rd_en && o_sts.join_ok);
        end
    end

    assign o_out_valid       = r_valid;
    assign o_cluster_index   = r_idx;
    assign o_opened_new      = r_new;
    assign o_table_full      = r_full;
    assign o_cluster_members = r_size;
endmodule

// File: design/fixed_width_leader_clustering_top.sv
// Top level of the fixed-width leader clustering block.
// Depends on flc_pkg, flc_if, flc_ctrl, flc_dp.
//
// Usage: samples arrive on the in channel (feature_a, feature_b, Q8.8) with a
// valid/ready transfer; one result per sample leaves on the out channel.
// width_squared is to be written through i_cfg_we/i_cfg_wdata only while idle; the block does not enforce this.
// Flow: an accepted sample is compared with each stored centroid, one
// cluster-RAM read per cycle. A join then fetches the best word and runs two
// 32-step bit-serial dividers side by side, then writes the entry back; an
// opened or dropped sample skips the dividers and the write-back, as does a
// join to a saturated cluster. One sample is in flight at a time; the next is
// accepted in the cycle after the result is loaded, so the rate is set by the
// RAM scan plus the divider loop.
// Reset: cluster count cleared, width_squared returns to 65536; RAM contents
// are not cleared since only written entries are read.
// Stall: the result register holds until taken; the next sample is accepted
// only after the previous result has been loaded into it.
module fixed_width_leader_clustering_top (
    input  logic i_clk,
    input  logic i_rst_n,
    flc_in_if.sink    i_in,
    flc_out_if.source o_out,
    input  logic i_cfg_we,
    input  logic [flc_pkg::DistBits-1:0] i_cfg_wdata
);
    import flc_pkg::*;

    logic [DistBits-1:0] r_width_sq;
    t_cmd w_cmd;
    t_sts w_sts;
    logic [CntBits-1:0] w_count;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_width_sq <= WidthSqReset;
        else if (i_cfg_we) r_width_sq <= i_cfg_wdata;
    end

    flc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready), .i_out_busy(o_out.valid && !o_out.ready),
        .i_sts(w_sts), .i_count(w_count), .o_cmd(w_cmd));

    flc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_feature_a(i_in.feature_a), .i_feature_b(i_in.feature_b),
        .i_width_sq(r_width_sq), .i_cmd(w_cmd), .o_sts(w_sts), .o_count(w_count),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_cluster_index(o_out.cluster_index), .o_opened_new(o_out.opened_new),
        .o_table_full(o_out.table_full), .o_cluster_members(o_out.cluster_members));
endmodule

// File: bench/tb_top.sv
// Self-checking bench for fixed_width_leader_clustering_top.
// Depends on flc_pkg and flc_if; a scoreboard class predicts each cluster result.
module tb_top;
    import flc_pkg::*;

    typedef struct {
        logic [IdxBits-1:0]   idx;
        logic                 opened;
        logic                 full;
        logic [CountBits-1:0] size;
    } t_cluster_result;

    // cluster table shadow and result queue
    class cluster_scoreboard;
        logic [DistBits-1:0]  width_sq;
        int                   n_clusters;
        logic signed [15:0]   cen_a[MaxClusters];
        logic signed [15:0]   cen_b[MaxClusters];
        logic signed [31:0]   acc_a[MaxClusters];
        logic signed [31:0]   acc_b[MaxClusters];
        logic [CountBits-1:0] members[MaxClusters];
        t_cluster_result      waiting[$];
        int                   errors;

        function new();
            width_sq   = WidthSqReset;
            n_clusters = 0;
            errors     = 0;
        endfunction

        function longint clamp32(longint s);
            if (s > 64'sd2147483647) return 64'sd2147483647;
            if (s < -64'sd2147483648) return -64'sd2147483648;
            return s;
        endfunction

        // nearest centroid search, join/open/drop decision
        function void note_sample(logic signed [15:0] a, logic signed [15:0] b);
            t_cluster_result r;
            longint da, db, d, best_d, sa, sb;
            int best;
            best = 0;
            best_d = 0;
            r = '{idx: '0, opened: 1'b0, full: 1'b0, size: '0};
            for (int i = 0; i < n_clusters; i++) begin
                da = longint'(a) - longint'(cen_a[i]);
                db = longint'(b) - longint'(cen_b[i]);
                d = da * da + db * db;
                if (i == 0 || d < best_d) begin
                    best_d = d;
                    best = i;
                end
            end
            if (n_clusters > 0 && best_d < longint'(width_sq)) begin
                if (members[best] != CountMax) begin
                    members[best] = members[best] + 1'b1;
                    sa = clamp32(longint'(acc_a[best]) + longint'(a));
                    sb = clamp32(longint'(acc_b[best]) + longint'(b));
                    acc_a[best] = sa[31:0];
                    acc_b[best] = sb[31:0];
                    cen_a[best] = 16'(sa / longint'(members[best]));
                    cen_b[best] = 16'(sb / longint'(members[best]));
                end
                r.idx = best[IdxBits-1:0];
                r.size = members[best];
            end else if (n_clusters >= MaxClusters) begin
                r.full = 1'b1;
            end else begin
                cen_a[n_clusters] = a;
                cen_b[n_clusters] = b;
                acc_a[n_clusters] = 32'(a);
                acc_b[n_clusters] = 32'(b);
                members[n_clusters] = 1;
                r.idx = n_clusters[IdxBits-1:0];
                r.opened = 1'b1;
                r.size = 1;
                n_clusters++;
            end
            waiting = {waiting, r};
        endfunction

        function void check_result(t_cluster_result got);
            t_cluster_result exp;
            if (waiting.size() == 0) begin
                $error("unexpected result transfer idx=%0d", got.idx);
                errors++;
                return;
            end
            exp = waiting.pop_front();
            if (got.idx !== exp.idx) begin
                $error("cluster_index exp %0d got %0d", exp.idx, got.idx);
                errors++;
            end
            if (got.opened !== exp.opened) begin
                $error("opened_new exp %0d got %0d", exp.opened, got.opened);
                errors++;
            end
            if (got.full !== exp.full) begin
                $error("table_full exp %0d got %0d", exp.full, got.full);
                errors++;
            end
            if (got.size !== exp.size) begin
                $error("cluster_members exp %0d got %0d", exp.size, got.size);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [DistBits-1:0] i_cfg_wdata;
    flc_in_if  in_ch ();
    flc_out_if out_ch ();

    fixed_width_leader_clustering_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    cluster_scoreboard sb = new();
    bit hold_off_req;
    bit sender_lowered;
    longint cycles;
    logic signed [15:0] centre_a[6];
    logic signed [15:0] centre_b[6];

    localparam longint CycleLimit = 2000000;
    localparam logic [DistBits-1:0] WidthSqMax = {DistBits{1'b1}};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one sample and wait for its transfer
    task automatic send_sample(logic signed [15:0] a, logic signed [15:0] b);
        int g;
        in_ch.valid     <= 1'b1;
        in_ch.feature_a <= a;
        in_ch.feature_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        g = pick_gap();
        sender_lowered = (g > 0);
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // drop valid, drain results, then let the block settle
    task automatic wait_idle();
        if (!sender_lowered) in_ch.valid <= 1'b0;
        sender_lowered = 1'b1;
        while (sb.waiting.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_width(logic [DistBits-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.width_sq = v;
    endtask

    // samples scattered round a few centres, some pure noise
    task automatic random_phase(int n_items, bit with_hold);
        int c;
        for (int k = 0; k < 6; k++) begin
            centre_a[k] = 16'($urandom);
            centre_b[k] = 16'($urandom);
        end
        for (int k = 0; k < n_items; k++) begin
            if (with_hold && k == n_items / 3) hold_off_req = 1'b1;
            if ($urandom_range(0, 99) < 15) begin
                send_sample(16'($urandom), 16'($urandom));
            end else begin
                c = $urandom_range(0, 5);
                send_sample(centre_a[c] + 16'($signed($urandom_range(0, 256)) - 128),
                            centre_b[c] + 16'($signed($urandom_range(0, 256)) - 128));
            end
        end
        wait_idle();
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if ($urandom_range(0, 99) < 25) begin
                out_ch.ready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(posedge i_clk);
            end
        end
    end

    // transfer monitor
    always @(posedge i_clk) begin
        t_cluster_result got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.feature_a, in_ch.feature_b);
            if (out_ch.valid && out_ch.ready) begin
                got.idx    = out_ch.cluster_index;
                got.opened = out_ch.opened_new;
                got.full   = out_ch.table_full;
                got.size   = out_ch.cluster_members;
                sb.check_result(got);
            end
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("fixed_width_leader_clustering_top verification failed");
                $finish;
            end
        end
    end

    initial begin
        hold_off_req    = 1'b0;
        sender_lowered  = 1'b1;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.feature_a <= '0;
        in_ch.feature_b <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // zero width: every sample opens
        write_width('0);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd100, 16'sd0);
        send_sample(-16'sd1, 16'sd1);
        wait_idle();

        // default width: tie between entries at 0 and 100, exact repeats
        write_width(WidthSqReset);
        send_sample(16'sd50, 16'sd0);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(16'sd50, 16'sd0);
        send_sample(16'sd300, 16'sd300);
        send_sample(-16'sd3, -16'sd5);
        wait_idle();

        // widest setting: all join the nearest
        write_width(WidthSqMax);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd1234, -16'sd4321);
        send_sample(-16'sd7, 16'sd9);
        wait_idle();

        // random part, table fills and then drops
        write_width(34'd4096);
        random_phase(130, 1'b0);
        write_width(WidthSqReset);
        random_phase(130, 1'b1);
        write_width(34'($urandom_range(0, 1 << 22)));
        random_phase(130, 1'b0);
        write_width(34'd1 << 20);
        random_phase(130, 1'b0);
        write_width('0);
        random_phase(120, 1'b0);
        write_width(WidthSqMax);
        random_phase(120, 1'b0);
        write_width({2'($urandom_range(0, 3)), 32'($urandom)});
        random_phase(120, 1'b0);

        if (sb.errors == 0 && sb.waiting.size() == 0) begin
            $display("fixed_width_leader_clustering_top verification clean");
        end else begin
            $display("fixed_width_leader_clustering_top verification failed");
        end
        $finish;
    end
endmodule

// File: fixed_width_leader_clustering_top.f
design/flc_pkg.sv
design/flc_if.sv
design/flc_ram.sv
design/flc_div.sv
design/flc_ctrl.sv
design/flc_dp.sv
design/fixed_width_leader_clustering_top.sv
bench/tb_top.sv
